@@ sv/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds at an edge -> cons holds at the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// cons holds whenever ante holds, same edge
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ sv/stp_pkg.sv @@
package stp_pkg;

   localparam int VALUE_W     = 32;  // req word payload width
   localparam int RSP_W       = 8;   // rsp word, result in bit 0
   localparam int SMALL_LIMIT = 4;   // values below this are never semiprime

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_EVAL,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic load;         // capture value, divisor = 2, factor search
      logic div_start;    // seed the divider with n / d
      logic div_step;     // one restoring-division bit
      logic next_d;       // try the next divisor
      logic to_cofactor;  // n <= quotient, start cofactor primality test
   } dp_cmd_type;

   typedef struct packed {
      logic tiny;         // factor phase and n < 4
      logic div_last;     // divider is on its final bit
      logic bound_fail;   // d > n / d, search exhausted
      logic rem_zero;     // d divides n
      logic cofactor;     // in cofactor phase
   } dp_status_type;

endpackage

@@ sv/stp_dpath.sv @@
module stp_dpath import stp_pkg::*; #(
   parameter int VB = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [VALUE_W-1:0]  value,
   input  dp_cmd_type          cmd,
   output dp_status_type       status
);

   localparam int CW = (VB > 1) ? $clog2(VB) : 1;

   logic [VB-1:0] n_ff, n_in;
   logic [VB-1:0] d_ff, d_in;
   logic [VB-1:0] quo_ff, quo_in;
   logic [VB-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          cof_ff, cof_in;

   logic [VB-1:0] value_n;
   logic [VB:0]   trial;
   logic          fits;

   // keep the low VB bits of the value, zero-extend when VB is wider
   always_comb begin
      value_n = '0;
      for (int i = 0; i < VB; i++) begin
         if (i < VALUE_W) begin
            value_n[i] = value[i];
         end
      end
   end

   // restoring division, one quotient bit a cycle
   assign trial = {rem_ff, quo_ff[VB-1]};
   assign fits  = (trial >= {1'b0, d_ff});

   always_comb begin
      n_in   = n_ff;
      d_in   = d_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      cof_in = cof_ff;
      if (cmd.load) begin
         n_in   = value_n;
         d_in   = {{(VB-2){1'b0}}, 2'd2};
         cof_in = 1'b0;
      end
      if (cmd.to_cofactor) begin
         n_in   = quo_ff;
         cof_in = 1'b1;
      end
      if (cmd.next_d) begin
         d_in = d_ff + 1'b1;
      end
      if (cmd.div_start) begin
         quo_in = n_ff;
         rem_in = '0;
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         quo_in = {quo_ff[VB-2:0], fits};
         rem_in = fits ? VB'(trial - {1'b0, d_ff}) : trial[VB-1:0];
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      d_ff   <= d_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         cof_ff <= 1'b0;
      end else begin
         cof_ff <= cof_in;
      end
   end

   assign status.tiny       = !cof_ff && (n_ff < VB'(SMALL_LIMIT));
   assign status.div_last   = (cnt_ff == CW'(VB - 1));
   assign status.bound_fail = (d_ff > quo_ff);
   assign status.rem_zero   = (rem_ff == '0);
   assign status.cofactor   = cof_ff;

endmodule

@@ sv/stp_ctrl.sv @@
module stp_ctrl import stp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic              rsp_bit,
   input  dp_status_type     status,
   output dp_cmd_type        cmd
);

   ctrl_state_type state_ff, state_in;
   logic           result_ff, result_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_bit_ff, rsp_bit_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_START;
         end
         ST_START: begin
            state_in = status.tiny ? ST_FINISH : ST_DIV;
         end
         ST_DIV: begin
            if (status.div_last) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (status.bound_fail) begin
               state_in = ST_FINISH;
            end else if (status.rem_zero) begin
               state_in = status.cofactor ? ST_FINISH : ST_START;
            end else begin
               state_in = ST_START;
            end
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and commands
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      result_in  = result_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_START: begin
            if (status.tiny) begin
               result_in = 1'b0;
            end else begin
               cmd.div_start = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_EVAL: begin
            if (status.bound_fail) begin
               // no divisor up to the root: prime, good only as cofactor
               result_in = status.cofactor;
            end else if (status.rem_zero) begin
               if (status.cofactor) begin
                  result_in = 1'b0;
               end else begin
                  cmd.to_cofactor = 1'b1;
               end
            end else begin
               cmd.next_d = 1'b1;
            end
         end
         ST_FINISH: ;
         default: ;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_bit_in   = rsp_bit_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (state_ff == ST_FINISH && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_bit_in   = result_ff;
      end
   end

   always_ff @(posedge clock) begin
      result_ff  <= result_in;
      rsp_bit_ff <= rsp_bit_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_bit    = rsp_bit_ff;

endmodule

@@ sv/semiprime_tester_top.sv @@
// Channel | Dir | Handshake              | Payload
// req     | in  | req_tvalid/req_tready  | req_tdata[31:0] value
// rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata[0] is_semiprime, [7:1] zero
//
// Sequence per candidate divisor: seed, VB restoring-division bits, decide.
// Reset: synchronous, active high; clears the controller state, output valid and the datapath cofactor flag.
// Stalls: one word in work at a time; req_tready is high only when idle.
//   A finished result waits in the output register; the next word can be
//   taken while it waits, and its own result holds back until it drains.
module semiprime_tester_top import stp_pkg::*; #(
   parameter int VALUE_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [VALUE_W-1:0] req_tdata,   // [31:0] value
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata    // [0] is_semiprime, [7:1] zero
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          rsp_bit;

   // controller: sequences seed / divide / decide, owns the output register
   stp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_bit    (rsp_bit),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: value, trial divisor, serial divider
   stp_dpath #(
      .VB (VALUE_BITS)
   ) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .value  (req_tdata),
      .cmd    (cmd),
      .status (status)
   );

   assign rsp_tdata = {{(RSP_W-1){1'b0}}, rsp_bit};

endmodule

@@ sv/stp_checker.sv @@
`include "assert_macros.svh"

module stp_checker import stp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [RSP_W-1:0]   rsp_tdata
);

   logic req_acc;
   logic rsp_stall;

   assign req_acc   = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid, "rsp word dropped")
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_tdata), "rsp word changed")
   // one word in work: input closes right after an accept
   `ASSERT_NEXT(a_one_busy, clock, reset, req_acc, !req_tready, "second word taken")
   // even the shortest word does not raise rsp_tvalid right after its accept
   `ASSERT_NEXT(a_no_early, clock, reset, req_acc, !$rose(rsp_tvalid), "result too early")
   `ASSERT_SAME(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[RSP_W-1:1] == '0, "pad bits")

endmodule

bind semiprime_tester_top stp_checker u_stp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
